@@ rtl/pds_pkg.sv @@
// pds_pkg: shared widths, constants and control types for proper_divisor_sum.
// Used by pds_divider, pds_datapath, pds_ctrl and the proper_divisor_sum top level.
// No dependencies.
package pds_pkg;

    // Default trial divisor limit (divisors below this are tried)
    localparam int PRIME_LIMIT_DEF = 320;

    // Field widths
    localparam int NUM_W  = 17;          // input number
    localparam int SUM_W  = 19;          // divisor_sum and abundance
    localparam int TERM_W = NUM_W + 1;   // 1+p+...+p^k and leftover+1
    localparam int PROD_W = 22;          // running sigma product

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Divider: quotient bits retired per cycle
    localparam int DIV_RADIX = 4;
    localparam int DIV_STEPS = (NUM_W + DIV_RADIX - 1) / DIV_RADIX;
    localparam int PAD_W     = DIV_STEPS * DIV_RADIX;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CHECK,
        ST_DIVIDE,
        ST_TERM,
        ST_MULT,
        ST_LEFT,
        ST_SUM,
        ST_OUT
    } pds_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture number, reset product and divisor
        logic square;      // register d*d
        logic div_start;   // start rest / d
        logic take_quot;   // rest <= quotient, pw <= pw*d
        logic add_term;    // term <= term + pw
        logic mul_term;    // prod <= prod*term, reset term and pw to one
        logic next_d;      // advance to the next candidate divisor
        logic mul_left;    // fold in leftover prime factor
        logic calc_sum;    // sigma - number, saturated
        logic load_out;    // fill the output register
    } pds_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_done;    // divider finished this cycle
        logic rem_zero;    // remainder of the finished division is zero
        logic past_limit;  // candidate divisor reached the limit
        logic sq_over;     // d*d exceeds what is left of the number
        logic found;       // current divisor divided at least once
        logic out_free;    // output register can take a word
    } pds_status_t;

endpackage

@@ rtl/pds_divider.sv @@
// pds_divider: iterative restoring divider, DIV_RADIX quotient bits per cycle.
// Depends on pds_pkg for the number width and step count.
// Start pulses load operands; done pulses in the cycle after the last step.
module pds_divider #(
    parameter int DW = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pds_pkg::NUM_W-1:0]  dividend,
    input  logic [DW-1:0]              divisor,
    output logic                       busy,
    output logic                       done,
    output logic [pds_pkg::NUM_W-1:0]  quotient,
    output logic [DW-1:0]              remainder
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [pds_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [pds_pkg::PAD_W-1:0]     acc_reg, acc_next;
    logic [DW-1:0]                 rem_reg, rem_next;
    logic [DW-1:0]                 dvs_reg, dvs_next;

    // step temporaries
    logic [DW:0]                   part;
    logic [pds_pkg::PAD_W-1:0]     shv;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // Each busy cycle: DIV_RADIX shift-compare-subtract steps.
    // acc holds unconsumed dividend bits on top, quotient bits fill from the bottom.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        part      = {1'b0, rem_reg};
        shv       = acc_reg;

        if (start)
        begin
            acc_next  = pds_pkg::PAD_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = pds_pkg::DIV_CNT_W'(pds_pkg::DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < pds_pkg::DIV_RADIX; i++)
            begin
                part = {part[DW-1:0], shv[pds_pkg::PAD_W-1]};
                shv  = {shv[pds_pkg::PAD_W-2:0], 1'b0};
                if (part >= {1'b0, dvs_reg})
                begin
                    part   = part - {1'b0, dvs_reg};
                    shv[0] = 1'b1;
                end
            end
            acc_next = shv;
            rem_next = part[DW-1:0];
            cnt_next = cnt_reg - pds_pkg::DIV_CNT_W'(1);
            if (cnt_reg == pds_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = acc_reg[pds_pkg::NUM_W-1:0];
    assign remainder = rem_reg;

endmodule

@@ rtl/pds_datapath.sv @@
// pds_datapath: factoring registers, multipliers, wheel divisor counter and
// output register. Depends on pds_pkg and pds_divider; driven by pds_ctrl.
module pds_datapath #(
    parameter int PRIME_LIMIT = pds_pkg::PRIME_LIMIT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pds_pkg::pds_cmd_t          cmd,
    output pds_pkg::pds_status_t       status,
    input  logic [pds_pkg::NUM_W-1:0]  number,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [pds_pkg::SUM_W-1:0]  divisor_sum,
    output logic                       is_abundant,
    output logic [pds_pkg::SUM_W-1:0]  abundance
);

    // Divisor width: holds a divisor below PRIME_LIMIT plus the largest wheel step
    localparam int DW    = $clog2(PRIME_LIMIT + 4);
    localparam int SQ_W  = 2 * DW;
    localparam int CMP_W = (SQ_W > pds_pkg::NUM_W) ? SQ_W : pds_pkg::NUM_W;
    localparam int NW    = pds_pkg::NUM_W;
    localparam int TW    = pds_pkg::TERM_W;
    localparam int PW    = pds_pkg::PROD_W;
    localparam int SW    = pds_pkg::SUM_W;

    logic [NW-1:0] n_reg;
    logic [NW-1:0] rest_reg;
    logic [NW-1:0] pw_reg;
    logic [TW-1:0] term_reg;
    logic [PW-1:0] prod_reg;
    logic [DW-1:0] d_reg;
    logic          wheel_reg;
    logic [SQ_W-1:0] dsq_reg;
    logic [SW-1:0] sum_reg;
    logic          out_valid_reg;
    logic [SW-1:0] out_sum_reg;
    logic          out_flag_reg;
    logic [SW-1:0] out_abund_reg;

    logic          div_busy;
    logic          div_done;
    logic [NW-1:0] div_quo;
    logic [DW-1:0] div_rem;

    logic [DW-1:0]    d_step;
    logic [SQ_W-1:0]  sq_prod;
    logic [NW+DW-1:0] pw_prod;
    logic [PW+TW-1:0] term_prod;
    logic [TW-1:0]    rest_inc;
    logic [PW+TW-1:0] left_prod;
    logic [PW-1:0]    excess;
    logic             sum_flag;

    pds_divider #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (rest_reg),
        .divisor   (d_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Wheel over 2, 3 and then numbers of the form 6k+-1
    always_comb
    begin
        if (d_reg == DW'(2))
            d_step = DW'(1);
        else if (d_reg < DW'(5))
            d_step = DW'(2);
        else if (wheel_reg)
            d_step = DW'(4);
        else
            d_step = DW'(2);
    end

    // Multipliers, each feeding a register
    assign sq_prod   = {{DW{1'b0}}, d_reg} * {{DW{1'b0}}, d_reg};
    assign pw_prod   = {{DW{1'b0}}, pw_reg} * {{NW{1'b0}}, d_reg};
    assign term_prod = {{TW{1'b0}}, prod_reg} * {{PW{1'b0}}, term_reg};
    assign rest_inc  = TW'(rest_reg) + TW'(1);
    assign left_prod = {{TW{1'b0}}, prod_reg} * {{PW{1'b0}}, rest_inc};

    // sigma - number, clamped at zero
    assign excess   = (prod_reg > PW'(n_reg)) ? prod_reg - PW'(n_reg) : '0;
    assign sum_flag = sum_reg > SW'(n_reg);

    // Factoring registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg     <= number;
            rest_reg  <= number;
            pw_reg    <= NW'(1);
            term_reg  <= TW'(1);
            prod_reg  <= PW'(1);
            d_reg     <= DW'(2);
            wheel_reg <= 1'b0;
        end
        else
        begin
            if (cmd.square)
                dsq_reg <= sq_prod;
            if (cmd.take_quot)
            begin
                rest_reg <= div_quo;
                pw_reg   <= pw_prod[NW-1:0];
            end
            if (cmd.add_term)
                term_reg <= term_reg + TW'(pw_reg);
            if (cmd.mul_term)
            begin
                prod_reg <= term_prod[PW-1:0];
                term_reg <= TW'(1);
                pw_reg   <= NW'(1);
            end
            if (cmd.next_d)
            begin
                d_reg <= d_reg + d_step;
                if (d_reg >= DW'(5))
                    wheel_reg <= !wheel_reg;
            end
            if (cmd.mul_left && (rest_reg > NW'(1)))
                prod_reg <= left_prod[PW-1:0];
            if (cmd.calc_sum)
            begin
                if (n_reg == '0)
                    sum_reg <= '0;
                else if (excess > PW'(pds_pkg::SUM_MAX))
                    sum_reg <= pds_pkg::SUM_MAX;
                else
                    sum_reg <= excess[SW-1:0];
            end
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_sum_reg   <= sum_reg;
            out_flag_reg  <= sum_flag;
            out_abund_reg <= sum_flag ? sum_reg - SW'(n_reg) : '0;
        end
    end

    // Status back to the controller
    assign status.div_done   = div_done;
    assign status.rem_zero   = (div_rem == '0);
    assign status.past_limit = (d_reg >= DW'(PRIME_LIMIT));
    assign status.sq_over    = CMP_W'(dsq_reg) > CMP_W'(rest_reg);
    assign status.found      = (term_reg != TW'(1));
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign divisor_sum = out_sum_reg;
    assign is_abundant = out_flag_reg;
    assign abundance   = out_abund_reg;

    // Divider is never restarted mid-division
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    // A word is never dropped from a stalled output register
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("output overwritten while stalled");

    // Removing a factor always shrinks what is left
    a_rest_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_quot && !cmd.load |=> rest_reg < $past(rest_reg))
        else $error("rest did not shrink after a factor was removed");

    // Candidate divisor only moves upward
    a_d_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.next_d && !cmd.load |=> d_reg > $past(d_reg))
        else $error("candidate divisor did not advance");

endmodule

@@ rtl/pds_ctrl.sv @@
// pds_ctrl: sequencing state machine for trial division and result delivery.
// Depends on pds_pkg for state, command and status types.
module pds_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pds_pkg::pds_status_t  status,
    output pds_pkg::pds_cmd_t     cmd
);

    pds_pkg::pds_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pds_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        unique case (state_reg)
            pds_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = pds_pkg::ST_SQUARE;
                end
            end
            pds_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = pds_pkg::ST_CHECK;
            end
            pds_pkg::ST_CHECK:
            begin
                // stop when divisors run out or d*d passes what is left
                if (status.past_limit || status.sq_over)
                    state_next = pds_pkg::ST_LEFT;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = pds_pkg::ST_DIVIDE;
                end
            end
            pds_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    if (status.rem_zero)
                    begin
                        cmd.take_quot = 1'b1;
                        state_next    = pds_pkg::ST_TERM;
                    end
                    else if (status.found)
                        state_next = pds_pkg::ST_MULT;
                    else
                    begin
                        cmd.next_d = 1'b1;
                        state_next = pds_pkg::ST_SQUARE;
                    end
                end
            end
            pds_pkg::ST_TERM:
            begin
                // accumulate this power and try the same divisor again
                cmd.add_term  = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = pds_pkg::ST_DIVIDE;
            end
            pds_pkg::ST_MULT:
            begin
                cmd.mul_term = 1'b1;
                cmd.next_d   = 1'b1;
                state_next   = pds_pkg::ST_SQUARE;
            end
            pds_pkg::ST_LEFT:
            begin
                cmd.mul_left = 1'b1;
                state_next   = pds_pkg::ST_SUM;
            end
            pds_pkg::ST_SUM:
            begin
                cmd.calc_sum = 1'b1;
                state_next   = pds_pkg::ST_OUT;
            end
            pds_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = pds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pds_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/proper_divisor_sum.sv @@
// proper_divisor_sum: sum of proper divisors, abundance flag and excess.
// Depends on pds_pkg, pds_ctrl, pds_datapath (which holds pds_divider).
//
//   channel  handshake            fields
//   in       in_valid / in_stall  number[16:0]
//   out      out_valid/out_stall  divisor_sum[18:0], is_abundant, abundance[18:0]
//
// One word is factored at a time. Each candidate divisor (2, 3, then 6k+-1 below
// PRIME_LIMIT) goes through square, check and a division in the 4-bit-per-cycle divider.
// A divisor that divides is tried again through the term state, and its term is then
// folded into the product in the multiply state.
// Reset is asynchronous and clears the controller and the output valid flag.
// A finished word waits in the output register; in_stall is low only when the
// controller is idle, which it reaches once that word is loaded into the output register.
module proper_divisor_sum #(
    parameter int PRIME_LIMIT = pds_pkg::PRIME_LIMIT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [pds_pkg::NUM_W-1:0]  number,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [pds_pkg::SUM_W-1:0]  divisor_sum,
    output logic                       is_abundant,
    output logic [pds_pkg::SUM_W-1:0]  abundance
);

    pds_pkg::pds_cmd_t    cmd;
    pds_pkg::pds_status_t status;

    pds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pds_datapath #(
        .PRIME_LIMIT (PRIME_LIMIT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .number      (number),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .divisor_sum (divisor_sum),
        .is_abundant (is_abundant),
        .abundance   (abundance)
    );

endmodule

@@ verif/proper_divisor_sum_test.sv @@
// proper_divisor_sum_test: self-checking bench for proper_divisor_sum; drives numbers, predicts
// the proper divisor sum, abundance flag and excess, and checks every output word in order.
// Depends on pds_pkg and the proper_divisor_sum RTL.
module proper_divisor_sum_test;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_WORDS   = 1700;
    localparam int TAIL_CYCLES    = 1200;     // longer than the slowest word
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_WORDS    = 200;

    // Idle patterns, stepped through as input words are accepted
    typedef enum int {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_LIGHT
    } idle_phase_t;

    typedef struct packed {
        logic [pds_pkg::SUM_W-1:0] divisor_sum;
        logic                      is_abundant;
        logic [pds_pkg::SUM_W-1:0] abundance;
    } divsum_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [pds_pkg::NUM_W-1:0] number = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [pds_pkg::SUM_W-1:0] divisor_sum;
    logic                      is_abundant;
    logic [pds_pkg::SUM_W-1:0] abundance;

    logic [pds_pkg::NUM_W-1:0] number_q[$];     // numbers waiting to be sent
    divsum_t          divsum_q[$];     // predicted output words, oldest first
    logic             in_acc = 1'b0;   // input word taken at the last rising edge
    int               in_cnt = 0;
    int               out_cnt = 0;
    int               abundant_cnt = 0;
    int               err_cnt = 0;
    int               quiet_cycles = 0;
    idle_phase_t      phase;
    divsum_t          got_w;
    divsum_t          want_w;

    proper_divisor_sum u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .number      (number),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .divisor_sum (divisor_sum),
        .is_abundant (is_abundant),
        .abundance   (abundance)
    );

    always #HALF_PERIOD clk = ~clk;

    // sigma(n) by trial division; a leftover above one counts as prime
    function automatic longint unsigned divisor_sigma(input longint unsigned n);
        longint unsigned rest;
        longint unsigned prod;
        longint unsigned d;
        longint unsigned term;
        longint unsigned pw;
        rest = n;
        prod = 1;
        for (d = 2; d < pds_pkg::PRIME_LIMIT_DEF && d * d <= rest; d++)
        begin
            if (rest % d == 0)
            begin
                term = 1;
                pw = 1;
                while (rest % d == 0)
                begin
                    rest = rest / d;
                    pw = pw * d;
                    term = term + pw;
                end
                prod = prod * term;
            end
        end
        if (rest > 1)
            prod = prod * (rest + 1);
        return prod;
    endfunction

    function automatic divsum_t classify_number(input logic [pds_pkg::NUM_W-1:0] num);
        longint unsigned n;
        longint unsigned s;
        longint unsigned sum;
        divsum_t         w;
        n = num;
        sum = 0;
        if (n != 0)
        begin
            s = divisor_sigma(n);
            sum = (s > n) ? s - n : 0;
            if (sum > pds_pkg::SUM_MAX)
                sum = pds_pkg::SUM_MAX;
        end
        w.divisor_sum = sum[pds_pkg::SUM_W-1:0];
        w.is_abundant = (sum > n);
        w.abundance   = (sum > n) ? pds_pkg::SUM_W'(sum - n) : '0;
        return w;
    endfunction

    always_comb
        phase = idle_phase_t'((in_cnt / PHASE_WORDS) % 4);

    // Driver: new input word and stall decision at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_acc)
            begin
                if (number_q.size() > 0 &&
                    $urandom_range(99) >= ((phase == PH_SEND_IDLE) ? 83 :
                                           (phase == PH_BOTH_LIGHT) ? 6 : 0))
                begin
                    in_valid <= 1'b1;
                    number   <= number_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                    number   <= pds_pkg::NUM_W'($urandom);
                end
            end
            out_stall <= ($urandom_range(99) < ((phase == PH_RECV_STALL) ? 83 :
                                                (phase == PH_BOTH_LIGHT) ? 6 : 0));
        end
    end

    // Monitor: predict on input accept, check on output accept
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_acc <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                divsum_q = {divsum_q, classify_number(number)};
                in_cnt <= in_cnt + 1;
            end
            if (out_valid && !out_stall)
            begin
                out_cnt <= out_cnt + 1;
                got_w = '{divisor_sum, is_abundant, abundance};
                if (got_w.is_abundant === 1'b1)
                    abundant_cnt <= abundant_cnt + 1;
                if (divsum_q.size() == 0)
                begin
                    $error("output word with nothing expected: divisor_sum %0d", divisor_sum);
                    err_cnt <= err_cnt + 1;
                end
                else
                begin
                    want_w = divsum_q.pop_front();
                    if (got_w !== want_w)
                    begin
                        err_cnt <= err_cnt + 1;
                        if (got_w.divisor_sum !== want_w.divisor_sum)
                            $error("divisor_sum: expected %0d, got %0d",
                                   want_w.divisor_sum, got_w.divisor_sum);
                        if (got_w.is_abundant !== want_w.is_abundant)
                            $error("is_abundant: expected %0d, got %0d",
                                   want_w.is_abundant, got_w.is_abundant);
                        if (got_w.abundance !== want_w.abundance)
                            $error("abundance: expected %0d, got %0d",
                                   want_w.abundance, got_w.abundance);
                    end
                end
            end
        end
    end

    // Watchdog: too long with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired after %0d idle cycles", quiet_cycles);
                $display("proper_divisor_sum_test: errors");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int unsigned directed[$];
        int unsigned near_primes[$];
        int unsigned v;
        int unsigned p;
        int          i;
        directed = '{0, 1, 2, 3, 4, 6, 12, 28, 945, 101, 317, 99221, 100489, 102399,
                     102400, 109561, 111547, 131071, 65536, 98304, 83160, 110880,
                     130321};
        near_primes = '{251, 257, 263, 269, 271, 277, 281, 283, 293, 307, 311, 313, 317,
                        331, 337, 347, 349, 353, 359};
        foreach (directed[k])
            number_q = {number_q, pds_pkg::NUM_W'(directed[k])};

        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: v = $urandom_range(1, 2000);
                4, 5, 6:    v = $urandom_range(1, 102399);
                7:          v = $urandom_range(0, 131071);
                8:
                begin
                    // two primes around the divisor limit, leftover may be composite
                    v = near_primes[$urandom_range(near_primes.size() - 1)] *
                        near_primes[$urandom_range(near_primes.size() - 1)];
                    if (v > 131071)
                        v = v / near_primes[0];
                end
                default:
                begin
                    // smooth number with repeated small factors
                    v = 1;
                    p = 2;
                    while (v * 7 <= 131071 && $urandom_range(7) != 0)
                    begin
                        case ($urandom_range(3))
                            0: p = 2;
                            1: p = 3;
                            2: p = 5;
                            default: p = 7;
                        endcase
                        v = v * p;
                    end
                end
            endcase
            number_q = {number_q, pds_pkg::NUM_W'(v)};
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (number_q.size() > 0 || in_valid || divsum_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (divsum_q.size() > 0)
            $error("%0d expected output words never arrived", divsum_q.size());
        $display("%0d numbers sent, %0d results checked, %0d of them abundant", in_cnt,
                 out_cnt, abundant_cnt);
        $display("covered free flow, heavy sender gaps, heavy output stalls, light both");
        if (err_cnt == 0 && divsum_q.size() == 0)
            $display("proper_divisor_sum_test: clean");
        else
            $display("proper_divisor_sum_test: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pds_pkg.sv
rtl/pds_divider.sv
rtl/pds_datapath.sv
rtl/pds_ctrl.sv
rtl/proper_divisor_sum.sv
verif/proper_divisor_sum_test.sv
